// File: rtl/hbwd_pkg.sv
//------------------------------------------------------------------------------
// Heartbeat watchdog package
// Shared types, command and event codes, and sizing constants.
//------------------------------------------------------------------------------
`default_nettype none

package hbwd_pkg;

	localparam int SLOTS_DEFAULT = 16;
	localparam int MAX_RESULTS   = 16;
	localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
	localparam int ID_W          = 31;
	localparam int MS_W          = 16;
	localparam logic [MS_W-1:0] TIMEOUT_RESET = 16'd15000;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef enum logic [1:0] {
		CMD_ENABLE  = 2'd0,
		CMD_DISABLE = 2'd1,
		CMD_KICK    = 2'd2,
		CMD_TICK    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_OK       = 3'd0,
		KIND_IGNORED  = 3'd1,
		KIND_FULL     = 3'd2,
		KIND_NONE     = 3'd3,
		KIND_RECOVERY = 3'd4,
		KIND_ABNORMAL = 3'd5
	} kind_t;

	typedef struct packed {
		cmd_t             command;
		logic [ID_W-1:0]  client_id;
		logic [MS_W-1:0]  elapsed_ms;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0] client;
		kind_t           kind;
		logic            last;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/hbwd_front.sv
//------------------------------------------------------------------------------
// Heartbeat watchdog front end
// Accepts requests, decodes the command and queues them for the slot engine.
//------------------------------------------------------------------------------
`default_nettype none

module hbwd_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire logic [1:0]                 command,
	input  wire logic [hbwd_pkg::ID_W-1:0]  client_id,
	input  wire logic [hbwd_pkg::MS_W-1:0]  elapsed_ms,
	output logic                            deq_valid,
	output hbwd_pkg::item_t                 deq_item,
	input  wire logic                       deq_pop
);

	hbwd_pkg::item_t                    mem_q [hbwd_pkg::QUEUE_DEPTH];
	logic [hbwd_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [hbwd_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [hbwd_pkg::QCNT_W-1:0]        cnt_q;
	logic                               do_wr;
	logic                               do_rd;
	hbwd_pkg::item_t                    wr_item;

	assign full      = (cnt_q == hbwd_pkg::QCNT_W'(hbwd_pkg::QUEUE_DEPTH));
	assign deq_valid = (cnt_q != '0);
	assign deq_item  = mem_q[rd_ptr_q];
	assign do_wr     = push && !full;
	assign do_rd     = deq_pop && deq_valid;

	always_comb begin
		wr_item.command    = hbwd_pkg::cmd_t'(command);
		wr_item.client_id  = client_id;
		wr_item.elapsed_ms = elapsed_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

// File: rtl/hbwd_res_fifo.sv
//------------------------------------------------------------------------------
// Heartbeat watchdog result queue
// Holds finished results until the consumer pops them.
//------------------------------------------------------------------------------
`default_nettype none

module hbwd_res_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire hbwd_pkg::result_t wr_res,
	output logic                  wr_full,
	output logic                  empty,
	input  wire logic             pop,
	output hbwd_pkg::result_t     rd_res
);

	hbwd_pkg::result_t                  mem_q [hbwd_pkg::QUEUE_DEPTH];
	logic [hbwd_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [hbwd_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [hbwd_pkg::QCNT_W-1:0]        cnt_q;
	logic                               do_wr;
	logic                               do_rd;

	assign wr_full = (cnt_q == hbwd_pkg::QCNT_W'(hbwd_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_res  = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !wr_full;
	assign do_rd   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_res;
		end
	end

endmodule

`default_nettype wire

// File: rtl/hbwd_back.sv
//------------------------------------------------------------------------------
// Heartbeat watchdog slot engine
// Walks slots one per cycle, unless results back up, to look up or age clients.
//------------------------------------------------------------------------------
`default_nettype none

module hbwd_back #(
	parameter int SLOTS = hbwd_pkg::SLOTS_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [hbwd_pkg::MS_W-1:0]  cfg_timeout,
	input  wire logic                       in_valid,
	input  wire hbwd_pkg::item_t            in_item,
	output logic                            in_pop,
	input  wire logic                       out_full,
	output logic                            out_push,
	output hbwd_pkg::result_t               out_res
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_CMD,
		ST_TICK,
		ST_TICK_END
	} state_t;

	state_t                          state_q;
	logic [IDX_W-1:0]                idx_q;
	logic                            found_q;
	logic [IDX_W-1:0]                found_idx_q;
	logic                            free_q;
	logic [IDX_W-1:0]                free_idx_q;
	logic                            pend_q;
	hbwd_pkg::result_t               pend_res_q;
	logic [hbwd_pkg::CNT_W-1:0]      n_q;
	hbwd_pkg::item_t                 item_q;
	logic [hbwd_pkg::MS_W-1:0]       timeout_q;

	logic                            slot_valid_q   [SLOTS];
	logic [hbwd_pkg::ID_W-1:0]       slot_client_q  [SLOTS];
	logic [hbwd_pkg::MS_W-1:0]       slot_rem_q     [SLOTS];
	logic                            slot_kicked_q  [SLOTS];
	logic                            slot_alarm_q   [SLOTS];

	logic                            cur_valid;
	logic [hbwd_pkg::ID_W-1:0]       cur_client;
	logic [hbwd_pkg::MS_W-1:0]       cur_rem;
	logic                            cur_kicked;
	logic                            cur_alarm;
	logic                            hit;
	logic [hbwd_pkg::MS_W-1:0]       sat_rem;
	logic [hbwd_pkg::MS_W-1:0]       new_rem;
	logic                            ev_rec;
	logic                            ev_abn;
	logic                            new_alarm;
	logic                            record;
	logic                            tick_go;
	hbwd_pkg::kind_t                 ev_kind;
	hbwd_pkg::kind_t                 cmd_kind;
	logic                            cmd_done;

	assign cur_valid  = slot_valid_q[idx_q];
	assign cur_client = slot_client_q[idx_q];
	assign cur_rem    = slot_rem_q[idx_q];
	assign cur_kicked = slot_kicked_q[idx_q];
	assign cur_alarm  = slot_alarm_q[idx_q];
	assign hit        = cur_valid && (cur_client == item_q.client_id);

	always_comb begin
		sat_rem   = (cur_rem > item_q.elapsed_ms) ? (cur_rem - item_q.elapsed_ms) : '0;
		new_rem   = cur_kicked ? cur_rem : sat_rem;
		ev_rec    = cur_alarm && (new_rem != '0);
		ev_abn    = (new_rem == '0) && !cur_alarm;
		new_alarm = ev_rec ? 1'b0 : (ev_abn ? 1'b1 : cur_alarm);
		ev_kind   = ev_rec ? hbwd_pkg::KIND_RECOVERY : hbwd_pkg::KIND_ABNORMAL;
		record    = cur_valid && (ev_rec || ev_abn) &&
		            (n_q < hbwd_pkg::CNT_W'(hbwd_pkg::MAX_RESULTS));
		// stall the walk only when the pending event cannot be flushed
		tick_go   = !(record && pend_q && out_full);
	end

	always_comb begin
		unique case (item_q.command)
			hbwd_pkg::CMD_ENABLE: begin
				cmd_kind = found_q ? hbwd_pkg::KIND_IGNORED :
				           (free_q ? hbwd_pkg::KIND_OK : hbwd_pkg::KIND_FULL);
			end
			hbwd_pkg::CMD_DISABLE,
			hbwd_pkg::CMD_KICK: begin
				cmd_kind = found_q ? hbwd_pkg::KIND_OK : hbwd_pkg::KIND_IGNORED;
			end
			default: begin
				cmd_kind = hbwd_pkg::KIND_NONE;
			end
		endcase
	end

	assign cmd_done = (state_q == ST_CMD) && !out_full;
	assign in_pop   = (state_q == ST_IDLE) && in_valid;

	always_comb begin
		out_push = 1'b0;
		out_res  = pend_res_q;
		unique case (state_q)
			ST_CMD: begin
				out_push       = !out_full;
				out_res.client = item_q.client_id;
				out_res.kind   = cmd_kind;
				out_res.last   = 1'b1;
			end
			ST_TICK: begin
				out_push     = record && pend_q && !out_full;
				out_res.last = 1'b0;
			end
			ST_TICK_END: begin
				out_push = !out_full;
				if (pend_q) begin
					out_res.last = 1'b1;
				end else begin
					out_res.client = '0;
					out_res.kind   = hbwd_pkg::KIND_NONE;
					out_res.last   = 1'b1;
				end
			end
			default: begin
				out_push = 1'b0;
			end
		endcase
	end

	// control state, valid bits and the timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			pend_q    <= 1'b0;
			n_q       <= '0;
			timeout_q <= hbwd_pkg::TIMEOUT_RESET;
			for (int i = 0; i < SLOTS; i++) begin
				slot_valid_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_timeout;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					free_q  <= 1'b0;
					pend_q  <= 1'b0;
					n_q     <= '0;
					if (in_valid) begin
						state_q <= (in_item.command == hbwd_pkg::CMD_TICK) ? ST_TICK : ST_FIND;
					end
				end
				ST_FIND: begin
					if (hit && !found_q) begin
						found_q <= 1'b1;
					end
					if (!cur_valid && !free_q) begin
						free_q <= 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= ST_CMD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CMD: begin
					if (cmd_done) begin
						if (item_q.command == hbwd_pkg::CMD_ENABLE && !found_q && free_q) begin
							slot_valid_q[free_idx_q] <= 1'b1;
						end
						if (item_q.command == hbwd_pkg::CMD_DISABLE && found_q) begin
							slot_valid_q[found_idx_q] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_TICK: begin
					if (tick_go) begin
						if (record) begin
							pend_q <= 1'b1;
							n_q    <= n_q + 1'b1;
						end
						if (idx_q == LAST_IDX) begin
							state_q <= ST_TICK_END;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_TICK_END: begin
					if (!out_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// slot payload and walk bookkeeping
	always_ff @(posedge clk) begin
		if (in_pop) begin
			item_q <= in_item;
		end
		if (state_q == ST_FIND) begin
			if (hit && !found_q) begin
				found_idx_q <= idx_q;
			end
			if (!cur_valid && !free_q) begin
				free_idx_q <= idx_q;
			end
		end
		if (cmd_done) begin
			if (item_q.command == hbwd_pkg::CMD_ENABLE && !found_q && free_q) begin
				slot_client_q[free_idx_q] <= item_q.client_id;
				slot_rem_q[free_idx_q]    <= timeout_q;
				slot_kicked_q[free_idx_q] <= 1'b1;
				slot_alarm_q[free_idx_q]  <= 1'b0;
			end
			if (item_q.command == hbwd_pkg::CMD_KICK && found_q) begin
				slot_rem_q[found_idx_q]    <= timeout_q;
				slot_kicked_q[found_idx_q] <= 1'b1;
			end
		end
		if (state_q == ST_TICK && tick_go) begin
			if (cur_valid) begin
				slot_rem_q[idx_q]    <= new_rem;
				slot_kicked_q[idx_q] <= 1'b0;
				slot_alarm_q[idx_q]  <= new_alarm;
			end
			if (record) begin
				pend_res_q.client <= cur_client;
				pend_res_q.kind   <= ev_kind;
				pend_res_q.last   <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/multi_client_heartbeat_watchdog.sv
//------------------------------------------------------------------------------
// Multi-client heartbeat watchdog
// Enable, disable and kick are dequeued, walk the slots one per cycle to look
// up the client, then commit once the result queue has room. A tick walks the
// slots one per cycle through the aging unit, stalling while results back up;
// one request is worked on at a time, so the next waits until this one ends.
// Reset (arst_n low) clears all slots, both queues and sets timeout to 15000.
//------------------------------------------------------------------------------
`default_nettype none

module multi_client_heartbeat_watchdog #(
	parameter int SLOTS = hbwd_pkg::SLOTS_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire logic [1:0]                 command,
	input  wire logic [hbwd_pkg::ID_W-1:0]  client_id,
	input  wire logic [hbwd_pkg::MS_W-1:0]  elapsed_ms,
	output logic                            empty,
	input  wire logic                       pop,
	output logic [hbwd_pkg::ID_W-1:0]       event_client,
	output logic [2:0]                      event_kind,
	output logic                            last_of_run,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [hbwd_pkg::MS_W-1:0]  cfg_data
);

	logic                 deq_valid;
	hbwd_pkg::item_t      deq_item;
	logic                 deq_pop;
	logic                 res_full;
	logic                 res_push;
	hbwd_pkg::result_t    res_in;
	hbwd_pkg::result_t    res_out;

	assign cfg_ready = 1'b1;

	hbwd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.client_id  (client_id),
		.elapsed_ms (elapsed_ms),
		.deq_valid  (deq_valid),
		.deq_item   (deq_item),
		.deq_pop    (deq_pop)
	);

	hbwd_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_timeout (cfg_data),
		.in_valid    (deq_valid),
		.in_item     (deq_item),
		.in_pop      (deq_pop),
		.out_full    (res_full),
		.out_push    (res_push),
		.out_res     (res_in)
	);

	hbwd_res_fifo u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_res  (res_in),
		.wr_full (res_full),
		.empty   (empty),
		.pop     (pop),
		.rd_res  (res_out)
	);

	assign event_client = res_out.client;
	assign event_kind   = 3'(res_out.kind);
	assign last_of_run  = res_out.last;

endmodule

`default_nettype wire

// File: rtl/hbwd_checker.sv
//------------------------------------------------------------------------------
// Heartbeat watchdog port checker
// Watches the top-level ports for malformed or unstable results.
//------------------------------------------------------------------------------
`default_nettype none

module hbwd_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       empty,
	input wire logic                       pop,
	input wire logic [hbwd_pkg::ID_W-1:0]  event_client,
	input wire logic [2:0]                 event_kind,
	input wire logic                       last_of_run
);

	// nothing is waiting right after reset releases
	a_empty_after_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> empty)
		else $error("result shown right after reset");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (event_kind <= 3'(hbwd_pkg::KIND_ABNORMAL)))
		else $error("undefined event kind");

	// the quiet tick result names no client and ends its run
	a_none_form: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind == 3'(hbwd_pkg::KIND_NONE)) |->
		(event_client == '0 && last_of_run))
		else $error("malformed no-event result");

	// command status results come alone
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (event_kind == 3'(hbwd_pkg::KIND_OK) ||
		            event_kind == 3'(hbwd_pkg::KIND_IGNORED) ||
		            event_kind == 3'(hbwd_pkg::KIND_FULL))) |-> last_of_run)
		else $error("status result not last of its run");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(event_client) &&
		$stable(event_kind) && $stable(last_of_run)))
		else $error("stalled result changed");

endmodule

bind multi_client_heartbeat_watchdog hbwd_checker u_hbwd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.event_client (event_client),
	.event_kind   (event_kind),
	.last_of_run  (last_of_run)
);

`default_nettype wire
